[rtl/sorted_priority_queue_unit_defines.svh]
// Assertion macros for the sorted priority queue unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define SPQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/spq_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// sorted priority queue unit. No dependencies.
package spq_pkg;

   localparam int CAPACITY_DEF    = 64;
   localparam int KEY_BITS_DEF    = 32;
   localparam int HANDLE_BITS_DEF = 16;

   // fixed port field widths
   localparam int OP_W     = 3;
   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 16;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_OFFER     = 3'd0;
   localparam logic [OP_W-1:0] OP_POLL      = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK      = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;
   localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic load;       // capture request, set up counters
      logic ins_rd;     // read slot idx-1
      logic ins_shift;  // move read entry up to slot idx, idx--
      logic ins_put;    // write new entry at idx
      logic pick_rd;    // read slot pos
      logic pick_cap;   // capture read entry as the returned one
      logic fil_rd;     // read slot i
      logic fil_step;   // keep or drop read entry, i++
      logic fil_end;    // count takes the write pointer
      logic set_empty;
      logic set_full;
      logic fire;       // load the result register
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            bad_pos;
      logic            idx_zero;
      logic            scan_done;
      logic            key_gt;
      logic            rsp_free;
   } stat_type;

endpackage

[rtl/spq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/spq_ctrl.sv]
// Sequencing state machine for the sorted priority queue unit.
// Depends on spq_pkg.
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_INS_RD   = 4'd2;
   localparam logic [3:0] S_INS_CHK  = 4'd3;
   localparam logic [3:0] S_PICK_RD  = 4'd4;
   localparam logic [3:0] S_PICK_CHK = 4'd5;
   localparam logic [3:0] S_FIL_RD   = 4'd6;
   localparam logic [3:0] S_FIL_CHK  = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op) inside
               spq_pkg::OP_OFFER: begin
                  if (stat.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end
               spq_pkg::OP_POLL, spq_pkg::OP_PEEK,
               spq_pkg::OP_READ_AT, spq_pkg::OP_REMOVE_AT: state_in = S_PICK_RD;
               spq_pkg::OP_REMOVE: state_in = S_FIL_RD;
               default: state_in = S_RESP;
            endcase
         end
         S_INS_RD: begin
            if (stat.idx_zero) begin
               cmd.ins_put = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (stat.key_gt) begin
               cmd.ins_shift = 1'b1;
               state_in      = S_INS_RD;
            end else begin
               cmd.ins_put = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_PICK_RD: begin
            if (stat.bad_pos) begin
               cmd.set_empty = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.pick_rd = 1'b1;
               state_in    = S_PICK_CHK;
            end
         end
         S_PICK_CHK: begin
            cmd.pick_cap = 1'b1;
            if (stat.op == spq_pkg::OP_POLL || stat.op == spq_pkg::OP_REMOVE_AT) begin
               state_in = S_FIL_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FIL_RD: begin
            if (stat.scan_done) begin
               cmd.fil_end = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.fil_rd = 1'b1;
               state_in   = S_FIL_CHK;
            end
         end
         S_FIL_CHK: begin
            cmd.fil_step = 1'b1;
            state_in     = S_FIL_RD;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.fire = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

[rtl/spq_datapath.sv]
// Entry store, counters and result register of the sorted priority queue.
// Depends on spq_pkg and spq_ram.
module spq_datapath #(
   parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
   parameter int KEY_BITS    = spq_pkg::KEY_BITS_DEF,
   parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spq_pkg::cmd_type              cmd,
   output spq_pkg::stat_type             stat,
   input  logic [spq_pkg::OP_W-1:0]      req_operation,
   input  logic [spq_pkg::KEY_W-1:0]     req_item_key,
   input  logic [spq_pkg::HANDLE_W-1:0]  req_item_handle,
   input  logic [spq_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [spq_pkg::HANDLE_W-1:0]  rsp_out_handle,
   output logic [spq_pkg::KEY_W-1:0]     rsp_out_key,
   output logic [spq_pkg::COUNT_W-1:0]   rsp_out_count,
   output logic [spq_pkg::COUNT_W-1:0]   rsp_queue_size
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > spq_pkg::POS_W) ? CW : spq_pkg::POS_W;
   localparam int DW   = KEY_BITS + HANDLE_BITS;

   logic [spq_pkg::OP_W-1:0]     op_ff;
   logic [KEY_BITS-1:0]          key_ff;
   logic [HANDLE_BITS-1:0]       hdl_ff;
   logic [spq_pkg::POS_W-1:0]    pos_ff;
   logic [CW-1:0]                count_ff, idx_ff, rd_ptr_ff, wr_ptr_ff, oc_ff;
   logic [KEY_BITS-1:0]          okey_ff;
   logic [HANDLE_BITS-1:0]       ohdl_ff;
   logic [spq_pkg::STATUS_W-1:0] st_ff;

   logic                         rsp_valid_ff;
   logic [spq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [spq_pkg::HANDLE_W-1:0] rsp_hdl_ff;
   logic [spq_pkg::KEY_W-1:0]    rsp_key_ff;
   logic [spq_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_size_ff;

   logic                          we;
   logic [AW-1:0]                 waddr, raddr;
   logic [DW-1:0]                 wdata, rdata;
   logic [KEY_BITS-1:0]           rd_key;
   logic [HANDLE_BITS-1:0]        rd_hdl;
   logic [CW-1:0]                 idx_m1, start_in;
   logic [CMPW-1:0]               pos_c;
   logic                          drop;
   logic                          is_pick_op;
   logic [spq_pkg::POS_W-1:0]     pos_in;

   assign rd_key = rdata[DW-1:HANDLE_BITS];
   assign rd_hdl = rdata[HANDLE_BITS-1:0];
   assign idx_m1 = idx_ff - CW'(1);
   assign pos_c  = CMPW'(pos_ff);
   assign drop   = (op_ff == spq_pkg::OP_REMOVE) ? (rd_hdl == hdl_ff)
                                                 : (CMPW'(rd_ptr_ff) == pos_c);

   // poll and peek work on the head
   assign is_pick_op = (req_operation == spq_pkg::OP_POLL) ||
                       (req_operation == spq_pkg::OP_PEEK);
   assign pos_in     = is_pick_op ? '0 : req_position;
   assign start_in   = (req_operation == spq_pkg::OP_REMOVE) ? '0 : CW'(CMPW'(pos_in));

   always_comb begin
      we    = 1'b0;
      waddr = idx_ff[AW-1:0];
      wdata = {key_ff, hdl_ff};
      raddr = rd_ptr_ff[AW-1:0];
      if (cmd.fil_rd) begin
         raddr = rd_ptr_ff[AW-1:0];
      end
      if (cmd.ins_rd) begin
         raddr = idx_m1[AW-1:0];
      end
      if (cmd.pick_rd) begin
         raddr = pos_c[AW-1:0];
      end
      if (cmd.ins_shift) begin
         we    = 1'b1;
         wdata = rdata;
      end
      if (cmd.ins_put) begin
         we = 1'b1;
      end
      if (cmd.fil_step && !drop) begin
         we    = 1'b1;
         waddr = wr_ptr_ff[AW-1:0];
         wdata = rdata;
      end
   end

   spq_ram #(
      .WIDTH(DW),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         key_ff    <= KEY_BITS'(req_item_key);
         hdl_ff    <= HANDLE_BITS'(req_item_handle);
         pos_ff    <= pos_in;
         idx_ff    <= count_ff;
         rd_ptr_ff <= start_in;
         wr_ptr_ff <= start_in;
         oc_ff     <= '0;
         okey_ff   <= '0;
         ohdl_ff   <= '0;
         st_ff     <= spq_pkg::ST_OK;
      end
      if (cmd.set_empty) st_ff <= spq_pkg::ST_EMPTY;
      if (cmd.set_full)  st_ff <= spq_pkg::ST_FULL;
      if (cmd.ins_shift) idx_ff <= idx_m1;
      if (cmd.ins_put)   oc_ff <= idx_ff;
      if (cmd.pick_cap) begin
         okey_ff <= rd_key;
         ohdl_ff <= rd_hdl;
      end
      if (cmd.fil_step) begin
         rd_ptr_ff <= rd_ptr_ff + CW'(1);
         if (drop) begin
            if (op_ff == spq_pkg::OP_REMOVE) oc_ff <= oc_ff + CW'(1);
         end else begin
            wr_ptr_ff <= wr_ptr_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.ins_put) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.fil_end) begin
         count_ff <= wr_ptr_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         rsp_status_ff <= st_ff;
         rsp_hdl_ff    <= spq_pkg::HANDLE_W'(ohdl_ff);
         rsp_key_ff    <= spq_pkg::KEY_W'(okey_ff);
         rsp_count_ff  <= spq_pkg::COUNT_W'(oc_ff);
         rsp_size_ff   <= spq_pkg::COUNT_W'(count_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_handle = rsp_hdl_ff;
   assign rsp_out_key    = rsp_key_ff;
   assign rsp_out_count  = rsp_count_ff;
   assign rsp_queue_size = rsp_size_ff;

   assign stat.op        = op_ff;
   assign stat.full      = (count_ff == CW'(CAPACITY));
   assign stat.bad_pos   = (pos_c >= CMPW'(count_ff));
   assign stat.idx_zero  = (idx_ff == '0);
   assign stat.scan_done = (rd_ptr_ff >= count_ff);
   assign stat.key_gt    = (rd_key > key_ff);
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

[rtl/sorted_priority_queue_unit.sv]
// Sorted priority queue unit: a key-ordered list of (key, handle) entries.
// Depends on spq_pkg, spq_ctrl, spq_datapath and the assertion macro header.
//
// Usage notes:
//  - Request channel req_*: one transfer carries an operation (offer, poll,
//    peek, read at, remove by handle, remove at) with its key, handle and
//    position. req_stall is high from the transfer until the result is
//    loaded into the output register.
//  - Result channel rsp_*: exactly one result per request, held in an
//    output register; while rsp_stall is high the result holds steady and a
//    new request is still taken and worked on, waiting only to be loaded.
//  - Entries live in one RAM; a walk reads each visited entry, then writes it
//    back unless it is dropped. Offer walks down from the tail, shifting larger
//    entries up; poll, peek, read at and remove at read one slot; poll, remove
//    at and remove by handle then compact the list in one pass.
//  - The unit takes a new request only once the result of the last one is
//    loaded, so the walk through the entry RAM bounds the throughput.
//  - Reset clears the entry count and the result valid; the RAM needs no
//    clearing since only slots below the count are ever read.
module sorted_priority_queue_unit #(
   parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
   parameter int KEY_BITS    = spq_pkg::KEY_BITS_DEF,
   parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [spq_pkg::OP_W-1:0]      req_operation,
   input  logic [spq_pkg::KEY_W-1:0]     req_item_key,
   input  logic [spq_pkg::HANDLE_W-1:0]  req_item_handle,
   input  logic [spq_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [spq_pkg::HANDLE_W-1:0]  rsp_out_handle,
   output logic [spq_pkg::KEY_W-1:0]     rsp_out_key,
   output logic [spq_pkg::COUNT_W-1:0]   rsp_out_count,
   output logic [spq_pkg::COUNT_W-1:0]   rsp_queue_size
);

`include "sorted_priority_queue_unit_defines.svh"

   spq_pkg::cmd_type  cmd;
   spq_pkg::stat_type stat;

   // sequencer
   spq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   // entry store, pointers and output register
   spq_datapath #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .HANDLE_BITS(HANDLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_operation),
      .req_item_key   (req_item_key),
      .req_item_handle(req_item_handle),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_handle (rsp_out_handle),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_count  (rsp_out_count),
      .rsp_queue_size (rsp_queue_size)
   );

   // a transfer always makes the unit busy on the next cycle
   `SPQ_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   // a full report never carries an insert position
   `SPQ_ASSERT_IMP(a_full_no_pos, clock, reset, rsp_valid && rsp_status == spq_pkg::ST_FULL, rsp_out_count == '0)
   // the result register is only loaded while the unit is busy
   `SPQ_ASSERT_IMP(a_fire_busy, clock, reset, cmd.fire, req_stall && stat.rsp_free)

endmodule

[verif/sorted_priority_queue_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_unit: directed and random
// operations checked against a sorted-list predictor. Depends on spq_pkg and the unit.

class spq_scoreboard;
   typedef struct packed {
      logic [spq_pkg::STATUS_W-1:0] status;
      logic [spq_pkg::HANDLE_W-1:0] handle;
      logic [spq_pkg::KEY_W-1:0]    key;
      logic [spq_pkg::COUNT_W-1:0]  count;
      logic [spq_pkg::COUNT_W-1:0]  size;
   } result_type;

   logic [spq_pkg::KEY_W-1:0]    keys[spq_pkg::CAPACITY_DEF];
   logic [spq_pkg::HANDLE_W-1:0] handles[spq_pkg::CAPACITY_DEF];
   int                           fill;
   result_type                   awaited[$];
   int                           errors;

   function new();
      fill = 0;
      errors = 0;
   endfunction

   function void drop(int p);
      for (int j = p; j + 1 < fill; j++) begin
         keys[j] = keys[j+1];
         handles[j] = handles[j+1];
      end
      fill--;
   endfunction

   // work out the result of one accepted transfer and queue it
   function void note_request(logic [spq_pkg::OP_W-1:0] op,
                              logic [spq_pkg::KEY_W-1:0] key,
                              logic [spq_pkg::HANDLE_W-1:0] hdl,
                              logic [spq_pkg::POS_W-1:0] pos);
      result_type r;
      int         p;
      int         w;
      r = '0;
      case (op)
         spq_pkg::OP_OFFER: begin
            if (fill >= spq_pkg::CAPACITY_DEF) r.status = spq_pkg::ST_FULL;
            else begin
               p = 0;
               while (p < fill && keys[p] <= key) p++;
               for (int i = fill; i > p; i--) begin
                  keys[i] = keys[i-1];
                  handles[i] = handles[i-1];
               end
               keys[p] = key;
               handles[p] = hdl;
               fill++;
               r.count = spq_pkg::COUNT_W'(p);
            end
         end
         spq_pkg::OP_POLL, spq_pkg::OP_PEEK: begin
            if (fill == 0) r.status = spq_pkg::ST_EMPTY;
            else begin
               r.handle = handles[0];
               r.key = keys[0];
               if (op == spq_pkg::OP_POLL) drop(0);
            end
         end
         spq_pkg::OP_READ_AT, spq_pkg::OP_REMOVE_AT: begin
            if (pos >= fill) r.status = spq_pkg::ST_EMPTY;
            else begin
               r.handle = handles[pos];
               r.key = keys[pos];
               if (op == spq_pkg::OP_REMOVE_AT) drop(pos);
            end
         end
         spq_pkg::OP_REMOVE: begin
            w = 0;
            for (int i = 0; i < fill; i++) begin
               if (handles[i] == hdl) r.count++;
               else begin
                  keys[w] = keys[i];
                  handles[w] = handles[i];
                  w++;
               end
            end
            fill = w;
         end
         default: ;
      endcase
      r.size = spq_pkg::COUNT_W'(fill);
      awaited.push_back(r);
   endfunction

   function void field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
         errors++;
      end
   endfunction

   function void check_result(result_type act);
      result_type e;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected result, got %0h", $time, act);
         errors++;
         return;
      end
      e = awaited.pop_front();
      field("status", 64'(e.status), 64'(act.status));
      field("out_handle", 64'(e.handle), 64'(act.handle));
      field("out_key", 64'(e.key), 64'(act.key));
      field("out_count", 64'(e.count), 64'(act.count));
      field("queue_size", 64'(e.size), 64'(act.size));
   endfunction

   function int pending();
      return awaited.size();
   endfunction
endclass

module sorted_priority_queue_unit_tb;
   // codes the block ignores
   localparam logic [spq_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [spq_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [spq_pkg::OP_W-1:0]     req_operation;
   logic [spq_pkg::KEY_W-1:0]    req_item_key;
   logic [spq_pkg::HANDLE_W-1:0] req_item_handle;
   logic [spq_pkg::POS_W-1:0]    req_position;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [spq_pkg::STATUS_W-1:0] rsp_status;
   logic [spq_pkg::HANDLE_W-1:0] rsp_out_handle;
   logic [spq_pkg::KEY_W-1:0]    rsp_out_key;
   logic [spq_pkg::COUNT_W-1:0]  rsp_out_count;
   logic [spq_pkg::COUNT_W-1:0]  rsp_queue_size;

   spq_scoreboard queue_model = new();

   int send_gap_pct  = 0;   // chance of an idle cycle after a transfer
   int recv_stall_pct = 0;  // chance of stalling the result channel
   int hold_left     = 0;   // long receiver hold-off, counted below

   sorted_priority_queue_unit DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generous ceiling for ~2000 transfers
   initial begin
      #5_000_000;
      $display("** sorted_priority_queue_unit: FAILED **");
      $finish;
   end

   // Result side: check every transfer, then pick next cycle's stall.
   // The hold-off stretch keeps stall high so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            queue_model.check_result({rsp_status, rsp_out_handle, rsp_out_key,
                                      rsp_out_count, rsp_queue_size});
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // One transfer; valid stays high into the next call unless a gap is drawn.
   task automatic send(logic [spq_pkg::OP_W-1:0] op, logic [spq_pkg::KEY_W-1:0] key,
                       logic [spq_pkg::HANDLE_W-1:0] hdl,
                       logic [spq_pkg::POS_W-1:0] pos);
      req_operation   <= op;
      req_item_key    <= key;
      req_item_handle <= hdl;
      req_position    <= pos;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      queue_model.note_request(op, key, hdl, pos);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
   endtask

   function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2, 3:    return spq_pkg::KEY_W'($urandom_range(15));   // plenty of equal keys
         default: return spq_pkg::KEY_W'($urandom);
      endcase
   endfunction

   function automatic logic [spq_pkg::HANDLE_W-1:0] pick_handle();
      if ($urandom_range(3) == 0) return spq_pkg::HANDLE_W'($urandom);
      return spq_pkg::HANDLE_W'($urandom_range(7));
   endfunction

   function automatic logic [spq_pkg::POS_W-1:0] pick_pos();
      int hi;
      if ($urandom_range(4) == 0) return spq_pkg::POS_W'($urandom);
      hi = queue_model.fill + 1;
      if (hi > 63) hi = 63;
      return spq_pkg::POS_W'($urandom_range(hi));
   endfunction

   // mostly well-formed mix; offer_pct steers the fill level
   task automatic random_item(int offer_pct);
      int roll;
      logic [spq_pkg::OP_W-1:0] op;
      logic [spq_pkg::HANDLE_W-1:0] hdl;
      roll = $urandom_range(99);
      if (roll < offer_pct) op = spq_pkg::OP_OFFER;
      else begin
         case ($urandom_range(12))
            0, 1, 2: op = spq_pkg::OP_POLL;
            3:       op = spq_pkg::OP_PEEK;
            4, 5:    op = spq_pkg::OP_READ_AT;
            6, 7:    op = spq_pkg::OP_REMOVE;
            8, 9, 10: op = spq_pkg::OP_REMOVE_AT;
            11:      op = OP_SPARE_A;
            default: op = OP_SPARE_B;
         endcase
      end
      hdl = pick_handle();
      // removes usually target a handle that is present
      if (op == spq_pkg::OP_REMOVE && queue_model.fill > 0 && $urandom_range(3) != 0)
         hdl = queue_model.handles[$urandom_range(queue_model.fill - 1)];
      send(op, pick_key(), hdl, pick_pos());
   endtask

   // the sender goes quiet first so nothing is taken twice
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (queue_model.pending() != 0) @(posedge clock);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = spq_pkg::OP_OFFER;
      req_item_key    = '0;
      req_item_handle = '0;
      req_position    = '0;
      rsp_stall       = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue cases first
      send(spq_pkg::OP_POLL, '0, '0, '0);
      send(spq_pkg::OP_PEEK, '0, '0, '0);
      send(spq_pkg::OP_READ_AT, '0, '0, '0);
      send(spq_pkg::OP_REMOVE_AT, '0, '0, 6'd63);
      send(spq_pkg::OP_REMOVE, '0, 16'hFFFF, '0);
      // poll of the only entry leaves the queue empty
      send(spq_pkg::OP_OFFER, 32'd5, 16'h1234, '0);
      send(spq_pkg::OP_POLL, '0, '0, '0);
      // extremes and equal keys in arrival order
      send(spq_pkg::OP_OFFER, 32'hFFFF_FFFF, 16'hFFFF, '0);
      send(spq_pkg::OP_OFFER, 32'h0, 16'h0, '0);
      send(spq_pkg::OP_OFFER, 32'd7, 16'h2, '0);
      send(spq_pkg::OP_OFFER, 32'd7, 16'h3, '0);
      send(spq_pkg::OP_OFFER, 32'd7, 16'h2, '0);
      send(spq_pkg::OP_READ_AT, '0, '0, 6'd3);
      send(spq_pkg::OP_READ_AT, '0, '0, 6'd5);        // past the end
      send(spq_pkg::OP_PEEK, '0, '0, '0);
      send(spq_pkg::OP_REMOVE, '0, 16'h2, '0);        // two matches
      send(spq_pkg::OP_REMOVE, '0, 16'hABCD, '0);     // no match
      send(spq_pkg::OP_REMOVE_AT, '0, '0, 6'd1);
      send(spq_pkg::OP_REMOVE_AT, '0, '0, 6'd40);
      send(OP_SPARE_A, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
      send(OP_SPARE_B, '0, '0, '0);
      wait_drained();

      // random phases: none, sender gaps, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
            default: begin send_gap_pct = 7; recv_stall_pct = 7; end
         endcase
         for (int n = 0; n < 400; n++) begin
            // every so often fill past capacity, then empty out
            if (n % 200 < 75) random_item(n % 200 < 70 && n % 200 >= 0 &&
                                          (n / 200) % 2 == ph % 2 ? 92 : 45);
            else random_item(n % 200 < 110 ? 10 : 45);
         end
      end

      // pressure: long receiver hold-off while transfers keep coming
      send_gap_pct = 0;
      recv_stall_pct = 0;
      hold_left = 400;
      for (int n = 0; n < 40; n++) random_item(60);
      // sender pauses until every result is back
      wait_drained();
      for (int n = 0; n < 250; n++) random_item(45);

      req_valid <= 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (queue_model.errors == 0)
         $display("** sorted_priority_queue_unit: PASSED **");
      else
         $display("** sorted_priority_queue_unit: FAILED **");
      $finish;
   end
endmodule
